// File: hdl/mhss_pkg.sv
package mhss_pkg;

    // Status byte fields and note kinds
    localparam logic [7:0] KIND_MASK     = 8'hF0;
    localparam logic [7:0] CHAN_MASK     = 8'h0F;
    localparam logic [7:0] NOTE_MASK     = 8'h7F;
    localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
    localparam logic [7:0] KIND_NOTE_OFF = 8'h80;

    // Input command codes
    localparam logic CMD_MSG  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes and reset values
    localparam logic REG_SILENCE_LIMIT = 1'b0;
    localparam logic REG_HELD_CAP      = 1'b1;
    localparam logic [30:0] SILENCE_LIMIT_RESET = 31'd10000;
    localparam logic [30:0] HELD_CAP_RESET      = 31'd60000;

    // Bitmap row address as carried between modules (up to 16 channels x 4 rows)
    localparam int ROW_MAX_W = 6;

    typedef struct packed {
        logic        cmd;
        logic [31:0] time_ms;
        logic [7:0]  status_byte;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
    } item_t;

    // delta_ms ends up in the lowest bits when packed onto tdata
    typedef struct packed {
        logic        recording;
        logic        episode_closed;
        logic        episode_opened;
        logic [11:0] held_notes;
        logic [31:0] delta_ms;
    } result_t;

    typedef struct packed {
        logic                 clear;
        logic                 wr_en;
        logic [ROW_MAX_W-1:0] row;
        logic [31:0]          data;
    } bm_upd_t;

endpackage

// File: hdl/mhss_bitmap.sv
module mhss_bitmap
    import mhss_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ROW_MAX_W-1:0] rd_row,
    input  logic [ROW_MAX_W-1:0] cur_row,
    input  logic                 advance,
    input  bm_upd_t              upd,
    output logic [31:0]          old_row
);

    localparam int ROWS  = CHANNELS * 4;
    localparam int ROW_W = $clog2(ROWS);

    logic [31:0]      mem [ROWS];
    logic [31:0]      rd_data_reg;
    logic [ROWS-1:0]  valid_reg;
    logic [ROWS-1:0]  valid_next;
    logic             fwd_en_reg;
    logic [ROW_W-1:0] fwd_row_reg;
    logic [31:0]      fwd_data_reg;

    logic [ROW_W-1:0] rd_idx;
    logic [ROW_W-1:0] cur_idx;
    logic [ROW_W-1:0] wr_idx;

    assign rd_idx  = rd_row[ROW_W-1:0];
    assign cur_idx = cur_row[ROW_W-1:0];
    assign wr_idx  = upd.row[ROW_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
        if (advance && upd.wr_en)
        begin
            mem[wr_idx] <= upd.data;
        end
    end

    // Valid bits stand in for clearing the whole bitmap at once
    always_comb
    begin
        valid_next = valid_reg;
        if (upd.clear)
        begin
            valid_next = '0;
        end
        if (upd.wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fwd_en_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg  <= valid_next;
            fwd_en_reg <= upd.wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_row_reg  <= wr_idx;
            fwd_data_reg <= upd.data;
        end
    end

    // The read may have been issued alongside the previous write; forward that write on a row match
    always_comb
    begin
        if (fwd_en_reg && (fwd_row_reg == cur_idx))
        begin
            old_row = fwd_data_reg;
        end
        else if (valid_reg[cur_idx])
        begin
            old_row = rd_data_reg;
        end
        else
        begin
            old_row = '0;
        end
    end

endmodule

// File: hdl/mhss_step.sv
module mhss_step
    import mhss_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  item_t       item,
    input  logic [31:0] old_row,
    input  logic [30:0] silence_limit,
    input  logic [30:0] held_cap,
    output result_t     result,
    output bm_upd_t     upd
);

    logic [11:0] total_reg;
    logic [11:0] total_next;
    logic [31:0] last_reg;
    logic [31:0] last_next;
    logic        active_reg;
    logic        active_next;

    logic        is_msg;
    logic        opening;
    logic        closing;
    logic [7:0]  kind;
    logic [7:0]  chan_byte;
    logic [7:0]  note_byte;
    logic [3:0]  chan;
    logic [6:0]  note;
    logic        chan_ok;
    logic [31:0] base_row;
    logic [11:0] base_total;
    logic [31:0] bit_mask;
    logic        cur_held;
    logic        is_on;
    logic        is_off;
    logic        set_bit;
    logic        clr_bit;
    logic [11:0] msg_total;
    logic [31:0] elapsed;

    always_comb
    begin
        is_msg    = (item.cmd == CMD_MSG);
        opening   = is_msg && !active_reg;
        kind      = item.status_byte & KIND_MASK;
        chan_byte = item.status_byte & CHAN_MASK;
        note_byte = item.data_first & NOTE_MASK;
        chan      = chan_byte[3:0];
        note      = note_byte[6:0];
        chan_ok   = ({1'b0, chan} < 5'(CHANNELS));

        // Opening an episode starts from an empty bitmap
        base_row   = opening ? '0 : old_row;
        base_total = opening ? '0 : total_reg;
        bit_mask   = 32'd1 << note[4:0];
        cur_held   = |(base_row & bit_mask);

        is_on   = (kind == KIND_NOTE_ON) && (item.data_second != 8'd0);
        is_off  = !is_on && ((kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON));
        set_bit = is_msg && chan_ok && is_on && !cur_held;
        clr_bit = is_msg && chan_ok && is_off && cur_held;

        if (set_bit)
        begin
            msg_total = base_total + 12'd1;
        end
        else if (clr_bit)
        begin
            msg_total = base_total - 12'd1;
        end
        else
        begin
            msg_total = base_total;
        end

        // Same subtraction serves as message delta and as tick quiet time
        elapsed = item.time_ms - last_reg;
        closing = !is_msg && active_reg && !elapsed[31]
                  && (elapsed >= {1'b0, silence_limit})
                  && ((total_reg == 12'd0) || (elapsed >= {1'b0, held_cap}));

        if (is_msg)
        begin
            active_next = 1'b1;
            total_next  = msg_total;
            last_next   = item.time_ms;
        end
        else
        begin
            active_next = closing ? 1'b0 : active_reg;
            total_next  = closing ? 12'd0 : total_reg;
            last_next   = last_reg;
        end

        result.delta_ms       = (is_msg && !opening) ? elapsed : 32'd0;
        result.held_notes     = total_next;
        result.episode_opened = opening;
        result.episode_closed = closing;
        result.recording      = active_next;

        upd.clear = opening || closing;
        upd.wr_en = set_bit || clr_bit;
        upd.row   = {chan, note[6:5]};
        upd.data  = set_bit ? (base_row | bit_mask) : (base_row & ~bit_mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            last_reg   <= '0;
            active_reg <= 1'b0;
        end
        else if (advance)
        begin
            total_reg  <= total_next;
            last_reg   <= last_next;
            active_reg <= active_next;
        end
    end

endmodule

// File: hdl/midi_held_note_silence_splitter.sv
// A request accepted into the working stage moves into the result register that drives m_tvalid.
// Throughput: one request per cycle while m_tready is high; the bitmap memory is read on accept and
// written when the request advances, with the last write forwarded, so no bubble is needed.
// Reset (rst_n low, asynchronous): drop all in-flight requests, close the episode,
// clear held count, last time and the bitmap valid bits; limits return to 10000 and 60000.
module midi_held_note_silence_splitter
    import mhss_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // time_ms[31:0], status_byte[39:32],
                                   // data_first[47:40], data_second[55:48]
    input  logic        s_tuser,   // cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // delta_ms[31:0], held_notes[43:32], episode_opened[44],
                                   // episode_closed[45], recording[46], zero[47]

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data
);

    logic        s1_valid_reg;
    item_t       s1_item_reg;
    logic        m_valid_reg;
    result_t     m_res_reg;
    logic [30:0] silence_limit_reg;
    logic [30:0] held_cap_reg;

    logic        accept;
    logic        advance;
    item_t       in_item;
    logic [31:0] old_row;
    result_t     step_res;
    bm_upd_t     upd;

    // Unpack the incoming request
    assign in_item.cmd         = s_tuser;
    assign in_item.time_ms     = s_tdata[31:0];
    assign in_item.status_byte = s_tdata[39:32];
    assign in_item.data_first  = s_tdata[47:40];
    assign in_item.data_second = s_tdata[55:48];

    // Advance the working stage whenever the result register is free or being emptied;
    // take a new request whenever the working stage is empty or advancing.
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, m_res_reg};
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the payload of the working stage and the result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (advance)
        begin
            m_res_reg <= step_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_limit_reg <= SILENCE_LIMIT_RESET;
            held_cap_reg      <= HELD_CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SILENCE_LIMIT: silence_limit_reg <= cfg_data;
                REG_HELD_CAP:      held_cap_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Read the bitmap row of the incoming note on accept (channel low nibble, note bits 6:5)
    mhss_bitmap #(
        .CHANNELS (CHANNELS)
    ) u_bitmap (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_row  ({s_tdata[35:32], s_tdata[46:45]}),
        .cur_row ({s1_item_reg.status_byte[3:0], s1_item_reg.data_first[6:5]}),
        .advance (advance),
        .upd     (upd),
        .old_row (old_row)
    );

    mhss_step #(
        .CHANNELS (CHANNELS)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .item          (s1_item_reg),
        .old_row       (old_row),
        .silence_limit (silence_limit_reg),
        .held_cap      (held_cap_reg),
        .result        (step_res),
        .upd           (upd)
    );

    // An episode cannot open and close on the same request
    a_open_close_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_res_reg.episode_opened && m_res_reg.episode_closed))
        else $error("episode opened and closed on one request");

    // A close leaves nothing held and the episode down
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_res_reg.episode_closed)
            |-> (m_res_reg.held_notes == 12'd0) && !m_res_reg.recording)
        else $error("close left notes held or recording on");

    // Outside an episode no note can be counted
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_res_reg.recording) |-> (m_res_reg.held_notes == 12'd0))
        else $error("held notes while not recording");

    // A stalled result must keep its working stage from advancing into it
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> m_valid_reg && $stable(m_res_reg))
        else $error("result register changed under stall");

endmodule
